@@ hw/rtl/mhsd_pkg.sv @@
// Shared types, codes and constants for the Mash distance sketch block.
package mhsd_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int HASH_BITS_DEF   = 64;

  localparam int HASH_W  = 64;
  localparam int LIMIT_W = 11;
  localparam int KMER_W  = 7;
  localparam int INTER_W = 11;
  localparam int UNION_W = 12;
  localparam int DIST_W  = 32;
  localparam int CNT_W   = 12;   // internal union/intersection counters
  localparam int OPND_W  = 21;   // log operands, wide enough for the clamp constants
  localparam int EXP_W   = 5;
  localparam int LN_W    = 40;   // Q32.32 natural log, integer part below 8 bits
  localparam int DIV_W   = 64;
  localparam int TERM_W  = 32;
  localparam int JIDX_W  = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [KMER_W-1:0]  KMER_RESET  = KMER_W'(21);

  localparam logic [DIV_W-1:0]  ONE_Q32 = DIV_W'(64'h1_0000_0000);
  localparam logic [TERM_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [JIDX_W-1:0] J_LIMIT = JIDX_W'(200);

  // Clamped operands: full union and empty intersection
  localparam logic [OPND_W-1:0] FULL_A  = OPND_W'(1000001);
  localparam logic [OPND_W-1:0] FULL_B  = OPND_W'(2);
  localparam logic [OPND_W-1:0] EMPTY_A = OPND_W'(1999999);
  localparam logic [OPND_W-1:0] EMPTY_B = OPND_W'(1999998);

  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_COMPUTE  = 2'd2
  } cmd_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_SKETCH_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH  = 1'd1;

  typedef struct packed {
    logic [1:0]        command;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic [INTER_W-1:0] intersection_count;
    logic [UNION_W-1:0] union_count;
    logic [DIST_W-1:0]  distance;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_resp_t;

  typedef struct packed {
    logic              start;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [KMER_W-1:0] k;
  } log_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
  } log_resp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MREAD,
    ST_MCMP,
    ST_TAIL,
    ST_FINISH,
    ST_WAIT
  } top_state_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_NORM,
    L_SDIV,
    L_SQ,
    L_SQ2,
    L_CHK,
    L_TDIV,
    L_TMUL,
    L_TMUL2,
    L_EMUL,
    L_LN,
    L_QDIV,
    L_QWAIT
  } log_state_t;

endpackage

@@ hw/rtl/minhash_sketch_mash_distance.sv @@
// Top level: sketch stores, merge sequencer and result register of the Mash distance block.
//
// Loads two bottom-k MinHash sketches (A and B), each hash sent largest first, and on a
// compute beat merges them from the smallest entry upward, counting intersection and
// union, then reports the Mash distance in unsigned Q8.24 and clears both sketches.
// A compute beat runs the merge steps (each a registered read of both sketch memories,
// then the compare), leaves the merge, runs the tail rounds, a finishing step and then
// the log stage: two natural logs, each one division for the series argument plus up
// to 100 series terms (each a check, a division and a multiply), and a final rounding
// division; all divisions share one radix-2 divider. When the union is empty or k is
// zero the log stage is skipped. Appends are still taken while a result waits on a
// stalled output; a compute waits until that result has left. Appends to a full store
// are dropped and flagged in the status of the next result.
module minhash_sketch_mash_distance #(
  parameter int MAX_ENTRIES = mhsd_pkg::MAX_ENTRIES_DEF,
  parameter int HASH_BITS   = mhsd_pkg::HASH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  mhsd_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output mhsd_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mhsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PW = $clog2(MAX_ENTRIES + 1);
  localparam int UW = mhsd_pkg::CNT_W;
  localparam int OW = mhsd_pkg::OPND_W;

  mhsd_pkg::top_state_t state, state_next;

  // Sketch memories
  logic [HASH_BITS-1:0] mem_a [MAX_ENTRIES];
  logic [HASH_BITS-1:0] mem_b [MAX_ENTRIES];
  logic [HASH_BITS-1:0] rd_a;
  logic [HASH_BITS-1:0] rd_b;

  logic [PW-1:0] count_a;
  logic [PW-1:0] count_b;
  logic          overflow_seen;
  logic          overflow_held;
  logic [PW-1:0] pa;
  logic [PW-1:0] pb;
  logic [UW-1:0] uni;
  logic [UW-1:0] inter;

  logic [mhsd_pkg::LIMIT_W-1:0] sketch_limit;
  logic [mhsd_pkg::KMER_W-1:0]  kmer_length;

  logic          item_accept;
  logic          is_append_a;
  logic          is_append_b;
  logic          is_compute;
  logic          we_a;
  logic          we_b;
  logic [PW-1:0] pa_m1;
  logic [PW-1:0] pb_m1;
  logic          merge_go;
  logic          tail_go;
  logic          skip_log;
  logic [1:0]    status_calc;
  logic [UW-1:0] limit_ext;

  mhsd_pkg::log_req_t  log_req;
  mhsd_pkg::log_resp_t log_resp;

  mhsd_log_engine u_log (
    .clk  (clk),
    .rst  (rst),
    .req  (log_req),
    .resp (log_resp)
  );

  assign cfg_ready = 1'b1;

  assign is_append_a = item.command == mhsd_pkg::CMD_APPEND_A;
  assign is_append_b = item.command == mhsd_pkg::CMD_APPEND_B;
  assign is_compute  = item.command == mhsd_pkg::CMD_COMPUTE;

  // Hold off while a compute is in progress; hold a compute back while the last result is still waiting
  assign item_stall  = (state != mhsd_pkg::ST_IDLE) || (result_valid && is_compute);
  assign item_accept = item_valid && !item_stall;

  assign we_a = item_accept && is_append_a && (count_a < PW'(MAX_ENTRIES));
  assign we_b = item_accept && is_append_b && (count_b < PW'(MAX_ENTRIES));

  assign pa_m1     = pa - PW'(1);
  assign pb_m1     = pb - PW'(1);
  assign limit_ext = UW'(sketch_limit);

  // Merge runs while both sides have entries and the union has not passed the limit
  assign merge_go = (pa != '0) && (pb != '0) && !(uni > limit_ext);
  // Tail rounds run while the union is below the limit and either side has entries
  assign tail_go  = (uni < limit_ext) && ((pa != '0) || (pb != '0));
  assign skip_log = (uni == '0) || (kmer_length == '0);

  assign status_calc = overflow_held ? mhsd_pkg::STATUS_OVERFLOW :
                       (uni == '0)   ? mhsd_pkg::STATUS_EMPTY : mhsd_pkg::STATUS_OK;

  // Log operands, clamped for a full union and an empty intersection
  always_comb begin
    log_req.start = (state == mhsd_pkg::ST_FINISH) && !skip_log;
    log_req.k     = kmer_length;
    priority if (inter >= uni) begin
      log_req.a = mhsd_pkg::FULL_A;
      log_req.b = mhsd_pkg::FULL_B;
    end else if (inter == '0) begin
      log_req.a = mhsd_pkg::EMPTY_A;
      log_req.b = mhsd_pkg::EMPTY_B;
    end else begin
      log_req.a = OW'({uni, 1'b0}) - OW'(inter);
      log_req.b = OW'({uni - inter, 1'b0});
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mhsd_pkg::ST_IDLE: begin
        if (item_accept && is_compute) state_next = mhsd_pkg::ST_MREAD;
      end
      mhsd_pkg::ST_MREAD:  state_next = merge_go ? mhsd_pkg::ST_MCMP : mhsd_pkg::ST_TAIL;
      mhsd_pkg::ST_MCMP:   state_next = mhsd_pkg::ST_MREAD;
      mhsd_pkg::ST_TAIL:   state_next = tail_go ? mhsd_pkg::ST_TAIL : mhsd_pkg::ST_FINISH;
      mhsd_pkg::ST_FINISH: state_next = skip_log ? mhsd_pkg::ST_IDLE : mhsd_pkg::ST_WAIT;
      mhsd_pkg::ST_WAIT: begin
        if (log_resp.done) state_next = mhsd_pkg::ST_IDLE;
      end
      default: state_next = mhsd_pkg::ST_IDLE;
    endcase
  end

  // Memory write on append, registered read at the merge pointers
  always_ff @(posedge clk) begin
    if (we_a) mem_a[count_a[AW-1:0]] <= item.hash_value[HASH_BITS-1:0];
    if (we_b) mem_b[count_b[AW-1:0]] <= item.hash_value[HASH_BITS-1:0];
    rd_a <= mem_a[pa_m1[AW-1:0]];
    rd_b <= mem_b[pb_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mhsd_pkg::ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
      result_valid  <= 1'b0;
      sketch_limit  <= mhsd_pkg::LIMIT_RESET;
      kmer_length   <= mhsd_pkg::KMER_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mhsd_pkg::CFG_SKETCH_LIMIT: sketch_limit <= cfg_data[mhsd_pkg::LIMIT_W-1:0];
          mhsd_pkg::CFG_KMER_LENGTH:  kmer_length  <= cfg_data[mhsd_pkg::KMER_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once it has been taken
      if (result_valid && !result_stall) result_valid <= 1'b0;

      unique case (state)
        mhsd_pkg::ST_IDLE: begin
          if (item_accept) begin
            if (is_append_a) begin
              if (we_a) count_a <= count_a + PW'(1);
              else      overflow_seen <= 1'b1;
            end else if (is_append_b) begin
              if (we_b) count_b <= count_b + PW'(1);
              else      overflow_seen <= 1'b1;
            end else if (is_compute) begin
              pa            <= count_a;
              pb            <= count_b;
              count_a       <= '0;
              count_b       <= '0;
              overflow_held <= overflow_seen;
              overflow_seen <= 1'b0;
              uni           <= '0;
              inter         <= '0;
            end
          end
        end
        mhsd_pkg::ST_MCMP: begin
          uni <= uni + UW'(1);
          priority if (rd_a == rd_b) begin
            inter <= inter + UW'(1);
            pa    <= pa_m1;
            pb    <= pb_m1;
          end else if (rd_a < rd_b) begin
            pa <= pa_m1;
          end else begin
            pb <= pb_m1;
          end
        end
        mhsd_pkg::ST_TAIL: begin
          if (tail_go) begin
            uni <= uni + UW'(pa != '0) + UW'(pb != '0);
            if (pa != '0) pa <= pa_m1;
            if (pb != '0) pb <= pb_m1;
          end
        end
        mhsd_pkg::ST_FINISH: begin
          result.intersection_count <= inter[mhsd_pkg::INTER_W-1:0];
          result.union_count        <= uni[mhsd_pkg::UNION_W-1:0];
          result.status             <= status_calc;
          result.distance           <= '1;
          if (skip_log) result_valid <= 1'b1;
        end
        mhsd_pkg::ST_WAIT: begin
          if (log_resp.done) begin
            result.distance <= log_resp.distance;
            result_valid    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/mhsd_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module mhsd_divider (
  input  logic                clk,
  input  logic                rst,
  input  mhsd_pkg::div_req_t  req,
  output mhsd_pkg::div_resp_t resp
);

  localparam int W   = mhsd_pkg::DIV_W;
  localparam int CW  = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W:0]    rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem[W-1:0], quo[W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse on the last quotient bit
      done <= busy && !req.start && (cnt == CW'(1));
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in one dividend bit, subtract where it fits
        if (fits) begin
          rem <= shifted - {1'b0, dvs};
        end else begin
          rem <= shifted;
        end
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign resp.done     = done;
  assign resp.quotient = quo;

endmodule

@@ hw/rtl/mhsd_log_engine.sv @@
// Log-ratio sequencer: atanh-series ln in Q32.32 on one multiplier and the shared divider.
module mhsd_log_engine (
  input  logic                clk,
  input  logic                rst,
  input  mhsd_pkg::log_req_t  req,
  output mhsd_pkg::log_resp_t resp
);

  localparam int W   = mhsd_pkg::DIV_W;
  localparam int TW  = mhsd_pkg::TERM_W;
  localparam int LW  = mhsd_pkg::LN_W;
  localparam int OW  = mhsd_pkg::OPND_W;
  localparam int EW  = mhsd_pkg::EXP_W;
  localparam int JW  = mhsd_pkg::JIDX_W;
  localparam int KW  = mhsd_pkg::KMER_W;

  mhsd_pkg::log_state_t state, state_next;

  logic [OW-1:0] opnd_b;
  logic [OW-1:0] n;
  logic [KW-1:0] k;
  logic          second;
  logic [EW-1:0] e;
  logic [TW-1:0] s;
  logic [TW-1:0] s2;
  logic [TW-1:0] term;
  logic [LW-1:0] sum;
  logic [JW-1:0] j;
  logic [LW-1:0] ln_a;
  logic [LW-1:0] ln_b;
  logic [W-1:0]  prod;
  logic          done;
  logic [mhsd_pkg::DIST_W-1:0] dist_q;

  logic [EW-1:0] e_calc;
  logic [W-1:0]  x;
  logic [TW-1:0] mul_x;
  logic [TW-1:0] mul_y;
  logic [LW-1:0] ln_val;
  logic [LW-1:0] diff;
  logic [KW+7:0] scale;

  mhsd_pkg::div_req_t  div_req;
  mhsd_pkg::div_resp_t div_resp;

  mhsd_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  // Leading-one position of the operand
  always_comb begin
    e_calc = '0;
    for (int i = 1; i < OW; i++) begin
      if (n[i]) begin
        e_calc = EW'(i);
      end
    end
  end

  assign x      = W'(n) << (6'd32 - 6'(e_calc));
  assign ln_val = LW'(prod) + {sum[LW-2:0], 1'b0};
  assign diff   = (ln_a > ln_b) ? ln_a - ln_b : '0;
  assign scale  = {k, 8'd0};

  always_comb begin
    unique case (state)
      mhsd_pkg::L_SQ:   begin mul_x = s;        mul_y = s;                 end
      mhsd_pkg::L_TMUL: begin mul_x = term;     mul_y = s2;                end
      mhsd_pkg::L_EMUL: begin mul_x = TW'(e);   mul_y = mhsd_pkg::LN2_Q32; end
      default:          begin mul_x = '0;       mul_y = '0;                end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= W'(mul_x) * W'(mul_y);
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = W'(1);
    unique case (state)
      mhsd_pkg::L_IDLE: begin
        if (req.start) state_next = mhsd_pkg::L_NORM;
      end
      mhsd_pkg::L_NORM: begin
        div_req.start    = 1'b1;
        div_req.dividend = (x - mhsd_pkg::ONE_Q32) << 32;
        div_req.divisor  = x + mhsd_pkg::ONE_Q32;
        state_next       = mhsd_pkg::L_SDIV;
      end
      mhsd_pkg::L_SDIV: begin
        if (div_resp.done) state_next = mhsd_pkg::L_SQ;
      end
      mhsd_pkg::L_SQ:  state_next = mhsd_pkg::L_SQ2;
      mhsd_pkg::L_SQ2: state_next = mhsd_pkg::L_CHK;
      mhsd_pkg::L_CHK: begin
        if (term != '0 && j < mhsd_pkg::J_LIMIT) begin
          div_req.start    = 1'b1;
          div_req.dividend = W'(term);
          div_req.divisor  = W'(j);
          state_next       = mhsd_pkg::L_TDIV;
        end else begin
          state_next = mhsd_pkg::L_EMUL;
        end
      end
      mhsd_pkg::L_TDIV: begin
        if (div_resp.done) state_next = mhsd_pkg::L_TMUL;
      end
      mhsd_pkg::L_TMUL:  state_next = mhsd_pkg::L_TMUL2;
      mhsd_pkg::L_TMUL2: state_next = mhsd_pkg::L_CHK;
      mhsd_pkg::L_EMUL:  state_next = mhsd_pkg::L_LN;
      mhsd_pkg::L_LN:    state_next = second ? mhsd_pkg::L_QDIV : mhsd_pkg::L_NORM;
      mhsd_pkg::L_QDIV: begin
        // round to nearest: (d + 128k) / 256k
        div_req.start    = 1'b1;
        div_req.dividend = W'(diff) + W'(scale >> 1);
        div_req.divisor  = W'(scale);
        state_next       = mhsd_pkg::L_QWAIT;
      end
      mhsd_pkg::L_QWAIT: begin
        if (div_resp.done) state_next = mhsd_pkg::L_IDLE;
      end
      default: state_next = mhsd_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhsd_pkg::L_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == mhsd_pkg::L_QWAIT) && div_resp.done;
      unique case (state)
        mhsd_pkg::L_IDLE: begin
          if (req.start) begin
            n      <= req.a;
            opnd_b <= req.b;
            k      <= req.k;
            second <= 1'b0;
          end
        end
        mhsd_pkg::L_NORM: e <= e_calc;
        mhsd_pkg::L_SDIV: begin
          if (div_resp.done) begin
            s    <= div_resp.quotient[TW-1:0];
            term <= div_resp.quotient[TW-1:0];
            sum  <= '0;
            j    <= JW'(1);
          end
        end
        mhsd_pkg::L_SQ2: s2 <= prod[W-1:32];
        mhsd_pkg::L_TDIV: begin
          if (div_resp.done) sum <= sum + LW'(div_resp.quotient[TW-1:0]);
        end
        mhsd_pkg::L_TMUL2: begin
          term <= prod[W-1:32];
          j    <= j + JW'(2);
        end
        mhsd_pkg::L_LN: begin
          if (second) begin
            ln_b <= ln_val;
          end else begin
            ln_a   <= ln_val;
            n      <= opnd_b;
            second <= 1'b1;
          end
        end
        mhsd_pkg::L_QWAIT: begin
          if (div_resp.done) begin
            dist_q <= (div_resp.quotient[W-1:32] != '0) ? '1 : div_resp.quotient[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign resp.done     = done;
  assign resp.distance = dist_q;

endmodule

@@ hw/rtl/mhsd_checker.sv @@
// Port-level checks on the result channel of the Mash distance block, bound to the top level.
module mhsd_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input mhsd_pkg::out_item_t result
);

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // An empty union reports all-ones distance and zero counts
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == mhsd_pkg::STATUS_EMPTY |->
      result.distance == '1 && result.union_count == '0 && result.intersection_count == '0)
    else $error("empty-union result malformed");

  // A zero union is never reported as ok
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.union_count == '0 |-> result.status != mhsd_pkg::STATUS_OK)
    else $error("zero union reported as ok");

  // Intersection never exceeds union
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> 12'(result.intersection_count) <= result.union_count)
    else $error("intersection above union");

endmodule

bind minhash_sketch_mash_distance mhsd_checker u_mhsd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
